FILE: rtl/plg_pkg.sv
// Shared types and constants for the power limit gain block.
package plg_pkg;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECIDE = 9'b000000010,
        ST_REG    = 9'b000000100,
        ST_FBMUL  = 9'b000001000,
        ST_DIV    = 9'b000010000,
        ST_POST   = 9'b000100000,
        ST_UV     = 9'b001000000,
        ST_SCALE  = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    // Which quotient the shared divider is producing
    typedef enum logic [1:0] {
        DIV_REGULAR  = 2'd0,
        DIV_FALLBACK = 2'd1,
        DIV_UNDERVOLT = 2'd2
    } div_kind_t;

    // Q1.15 gains
    localparam logic [15:0] Q_ONE      = 16'd32768;
    localparam logic [15:0] GAIN_FLOOR = 16'd655;
    localparam logic [15:0] GAIN_LOCAL = 16'd3277;
    localparam logic [15:0] FB_LOW     = 16'd16384;
    localparam logic [15:0] FB_HIGH    = 16'd26214;
    localparam logic [15:0] OVF_STEP   = 16'd983;
    localparam logic [15:0] OVF_MIN    = 16'd26214;
    localparam logic [15:0] OVF_KNEE   = 16'd27197;

    // Charge levels, 1/300 percent
    localparam logic [14:0] CAP_FULL      = 15'd30000;
    localparam logic [14:0] FLOOR_RESET   = 15'd9000;
    localparam logic [14:0] SPAN_DEFAULT  = 15'd3000;
    localparam logic [14:0] FLOOR_BOOST   = 15'd12000;
    localparam logic [14:0] FLOOR_TOP     = 15'd27000;
    localparam logic [14:0] CAP_TOP_KNEE  = 15'd27900;
    localparam logic [14:0] CAP_BOOST_KNEE = 15'd18000;
    localparam logic [14:0] CAP_IDLE_KNEE = 15'd15000;
    localparam logic [14:0] WINDOW_OFFSET = 15'd6000;

    // Buffer energy, joules
    localparam logic [7:0] BUF_MAX     = 8'd60;
    localparam logic [7:0] BUF_HEALTHY = 8'd40;
    localparam logic [7:0] BUF_BASE    = 8'd10;
    localparam logic [7:0] BUF_STEP    = 8'd20;
    localparam logic [15:0] BUF_SCALE  = 16'd50;

    localparam logic [1:0] BOOST_NONE = 2'd0;
    localparam logic [1:0] BOOST_JUMP = 2'd3;

endpackage

FILE: rtl/power_limit_gain.sv
// Power limit gain: window, fallback and under-voltage gain with a shared serial divider.
// The window or fallback gain and the under-voltage factor may each need a quotient from the
// divider. A new item is not taken before the last one is through; s_tready is high only
// while the sequencer is idle, and a finished result may wait in the output register while
// the next item is taken.
// Reset (aresetn low, synchronous): sequencer idle, no result pending, window 9000/3000,
// previous boost 0, over-limit gain 1.0, divider count 0, last under-voltage factor 1.0.
module power_limit_gain
    import plg_pkg::*;
#(
    parameter int DIVIDE_RATIO = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cap_level[14:0], buffer_energy[22:15], boost_level[24:23], module_offline[25],
    // referee_offline[26], cap_healthy[27], allowed_current[43:28],
    // present_current[59:44], zero[63:60]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // limit_gain[15:0], undervolt_gain[31:16]
    output logic [31:0] m_tdata
);

    localparam logic [6:0] RATIO = 7'(DIVIDE_RATIO);

    state_t      state_reg, state_next;
    div_kind_t   kind_reg;

    // latched item
    logic [14:0] cap_reg;
    logic [7:0]  buf_reg;
    logic [1:0]  boost_reg;
    logic        mod_off_reg, ref_off_reg, healthy_reg;
    logic [15:0] allowed_reg, present_reg;

    // block state
    logic [14:0] floor_reg, span_reg;
    logic [1:0]  prev_boost_reg;
    logic [15:0] ovf_reg;
    logic [6:0]  fb_div_reg;
    logic [15:0] last_uv_reg;

    // working registers
    logic [15:0] gain_reg, uv_reg;
    logic [15:0] rem_reg, dvd_reg, dsr_reg;
    logic [3:0]  cnt_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    logic        s_xfer;
    logic        out_free;
    logic        regular_mode;
    logic [14:0] cap_in;
    logic [14:0] floor_new;
    logic [14:0] cap_diff;
    logic [6:0]  fb_d;
    logic [7:0]  buf_clamp;
    logic [5:0]  buf_excess;
    logic [21:0] fb_prod;
    logic [31:0] scale_prod;
    logic [16:0] trial_in;
    logic [17:0] trial_diff;
    logic        trial_ge;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cap_in = (s_tdata[14:0] > CAP_FULL) ? CAP_FULL : s_tdata[14:0];
    assign regular_mode = !mod_off_reg && (healthy_reg || buf_reg >= BUF_HEALTHY);

    // window floor for the current boost level
    always_comb begin
        floor_new = floor_reg;
        if (boost_reg == BOOST_JUMP) begin
            floor_new = FLOOR_BOOST;
        end else if (boost_reg != BOOST_NONE) begin
            if (prev_boost_reg == BOOST_NONE) begin
                floor_new = (cap_reg > CAP_BOOST_KNEE) ? cap_reg - WINDOW_OFFSET : FLOOR_BOOST;
            end
        end else if (cap_reg >= CAP_TOP_KNEE) begin
            floor_new = FLOOR_TOP;
        end else begin
            floor_new = (cap_reg > CAP_IDLE_KNEE) ? cap_reg - WINDOW_OFFSET : FLOOR_RESET;
            if (floor_new > FLOOR_TOP) begin
                floor_new = FLOOR_TOP;
            end
        end
    end

    assign cap_diff   = cap_reg - floor_reg;
    assign fb_d       = (fb_div_reg >= RATIO) ? fb_div_reg - RATIO : fb_div_reg;
    assign buf_clamp  = (buf_reg > BUF_MAX) ? BUF_MAX : buf_reg;
    assign buf_excess = 6'(buf_clamp - BUF_BASE);
    assign fb_prod    = 22'(buf_excess) * 22'(ovf_reg);
    assign scale_prod = 32'(gain_reg) * 32'(uv_reg);

    // one restoring divider step
    assign trial_in   = {rem_reg, dvd_reg[15]};
    assign trial_diff = {1'b0, trial_in} - {2'b00, dsr_reg};
    assign trial_ge   = !trial_diff[17];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_xfer) state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (regular_mode)     state_next = ST_REG;
                else if (!ref_off_reg) state_next = ST_FBMUL;
                else                  state_next = ST_UV;
            end
            ST_REG: begin
                if (cap_reg <= floor_reg || span_reg == '0 || cap_diff >= span_reg)
                    state_next = ST_UV;
                else
                    state_next = ST_DIV;
            end
            ST_FBMUL:  state_next = (buf_reg <= BUF_BASE) ? ST_UV : ST_DIV;
            ST_DIV:    if (cnt_reg == 4'hF) state_next = ST_POST;
            ST_POST:   state_next = (kind_reg == DIV_UNDERVOLT) ? ST_SCALE : ST_UV;
            ST_UV: begin
                if (mod_off_reg || present_reg == '0) state_next = ST_FINISH;
                else if (allowed_reg >= present_reg)  state_next = ST_SCALE;
                else                                  state_next = ST_DIV;
            end
            ST_SCALE:  state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            floor_reg      <= FLOOR_RESET;
            span_reg       <= SPAN_DEFAULT;
            prev_boost_reg <= BOOST_NONE;
            ovf_reg        <= Q_ONE;
            fb_div_reg     <= '0;
            last_uv_reg    <= Q_ONE;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == ST_DECIDE) begin
                if (regular_mode) begin
                    floor_reg      <= floor_new;
                    prev_boost_reg <= boost_reg;
                    if (boost_reg == BOOST_NONE || boost_reg == BOOST_JUMP ||
                        prev_boost_reg == BOOST_NONE) begin
                        span_reg <= SPAN_DEFAULT;
                    end
                end else if (!ref_off_reg) begin
                    // slow over-limit step, once per divider period
                    if (fb_d == '0 && buf_reg <= BUF_STEP) begin
                        ovf_reg <= (ovf_reg > OVF_KNEE) ? ovf_reg - OVF_STEP : OVF_MIN;
                    end
                    fb_div_reg <= fb_d + 7'd1;
                end
            end
            if (state_reg == ST_SCALE) begin
                last_uv_reg <= uv_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    cap_reg     <= cap_in;
                    buf_reg     <= s_tdata[22:15];
                    boost_reg   <= s_tdata[24:23];
                    mod_off_reg <= s_tdata[25];
                    ref_off_reg <= s_tdata[26];
                    healthy_reg <= s_tdata[27];
                    allowed_reg <= s_tdata[43:28];
                    present_reg <= s_tdata[59:44];
                end
            end
            ST_DECIDE: begin
                if (!regular_mode && ref_off_reg) begin
                    gain_reg <= GAIN_LOCAL;
                end
            end
            ST_REG: begin
                if (cap_reg <= floor_reg) begin
                    gain_reg <= GAIN_FLOOR;
                end else if (span_reg == '0 || cap_diff >= span_reg) begin
                    gain_reg <= Q_ONE;
                end else begin
                    // dividend is the charge offset shifted up by 15
                    rem_reg  <= {2'b00, cap_diff[14:1]};
                    dvd_reg  <= {cap_diff[0], 15'd0};
                    dsr_reg  <= {1'b0, span_reg};
                    kind_reg <= DIV_REGULAR;
                    cnt_reg  <= '0;
                end
            end
            ST_FBMUL: begin
                if (buf_reg <= BUF_BASE) begin
                    gain_reg <= FB_LOW;
                end else begin
                    rem_reg  <= {10'd0, fb_prod[21:16]};
                    dvd_reg  <= fb_prod[15:0];
                    dsr_reg  <= BUF_SCALE;
                    kind_reg <= DIV_FALLBACK;
                    cnt_reg  <= '0;
                end
            end
            ST_DIV: begin
                rem_reg <= trial_ge ? trial_diff[15:0] : trial_in[15:0];
                dvd_reg <= {dvd_reg[14:0], trial_ge};
                cnt_reg <= cnt_reg + 4'd1;
            end
            ST_POST: begin
                case (kind_reg)
                    DIV_REGULAR:  gain_reg <= (dvd_reg < GAIN_FLOOR) ? GAIN_FLOOR : dvd_reg;
                    DIV_FALLBACK: begin
                        if (dvd_reg < FB_LOW)       gain_reg <= FB_LOW;
                        else if (dvd_reg > FB_HIGH) gain_reg <= FB_HIGH;
                        else                        gain_reg <= dvd_reg;
                    end
                    default:      uv_reg <= dvd_reg;
                endcase
            end
            ST_UV: begin
                if (allowed_reg >= present_reg) begin
                    uv_reg <= Q_ONE;
                end else begin
                    rem_reg  <= {1'b0, allowed_reg[15:1]};
                    dvd_reg  <= {allowed_reg[0], 15'd0};
                    dsr_reg  <= present_reg;
                    kind_reg <= DIV_UNDERVOLT;
                    cnt_reg  <= '0;
                end
            end
            ST_SCALE: begin
                gain_reg <= scale_prod[30:15];
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tdata_reg <= {last_uv_reg, gain_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // checks
    a_ovf_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg >= OVF_MIN && ovf_reg <= Q_ONE)
        else $error("over-limit gain out of range");

    a_span_fixed: assert property (@(posedge aclk) disable iff (!aresetn)
        span_reg == SPAN_DEFAULT)
        else $error("window span moved");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fb_div_reg <= RATIO)
        else $error("fallback divider beyond ratio");

    a_out_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg != 4'hF) |=> state_reg == ST_DIV)
        else $error("divider left early");

endmodule

FILE: bench/power_limit_gain_tb.sv
// Self-checking testbench for the power limit gain block: directed ticks, then random ticks.
`timescale 1ns / 1ps

module power_limit_gain_tb
    import plg_pkg::*;
();

    localparam int RATIO         = 100;
    localparam int RANDOM_TICKS  = 630;
    localparam int MAX_REPORTS   = 100;
    localparam logic [15:0] READY_PATTERN = 16'b1101_0111_0110_1011;

    // One control tick, packed as on s_tdata (lowest field in the lowest bits)
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] present_current;
        logic [15:0] allowed_current;
        logic        cap_healthy;
        logic        referee_offline;
        logic        module_offline;
        logic [1:0]  boost_level;
        logic [7:0]  buffer_energy;
        logic [14:0] cap_level;
    } tick_t;

    // One result, packed as on m_tdata
    typedef struct packed {
        logic [15:0] undervolt_gain;
        logic [15:0] limit_gain;
    } gain_result_t;

    typedef enum logic [1:0] {MODE_REGULAR, MODE_FALLBACK, MODE_LOCAL} tick_mode_t;
    typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_RANDOM} stall_style_t;

    // Gain predictor and store of expected results
    class gain_scoreboard;
        logic [14:0]  win_floor;
        logic [14:0]  win_span;
        logic [1:0]   prev_boost;
        logic [15:0]  ovf_gain;
        logic [6:0]   fb_count;
        logic [15:0]  uv_last;
        gain_result_t expected_q[$];
        int unsigned  errors;

        function new();
            win_floor  = FLOOR_RESET;
            win_span   = SPAN_DEFAULT;
            prev_boost = BOOST_NONE;
            ovf_gain   = Q_ONE;
            fb_count   = '0;
            uv_last    = Q_ONE;
            errors     = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        // Work out the result of an accepted tick and queue it
        function void note_input(tick_t t);
            int unsigned cap;
            int unsigned energy;
            int unsigned gain;
            int unsigned flr;
            int unsigned div;
            int unsigned factor;
            gain_result_t res;
            cap    = (t.cap_level > CAP_FULL) ? CAP_FULL : t.cap_level;
            energy = (t.buffer_energy > BUF_MAX) ? BUF_MAX : t.buffer_energy;

            if (!t.module_offline && (t.cap_healthy || energy >= BUF_HEALTHY)) begin
                // window follows the boost level
                if (t.boost_level == BOOST_JUMP) begin
                    win_floor = FLOOR_BOOST;
                    win_span  = SPAN_DEFAULT;
                end else if (t.boost_level != BOOST_NONE) begin
                    if (prev_boost == BOOST_NONE) begin
                        win_floor = (cap > CAP_BOOST_KNEE) ? 15'(cap - WINDOW_OFFSET)
                                                           : FLOOR_BOOST;
                        win_span  = SPAN_DEFAULT;
                    end
                end else begin
                    if (cap >= CAP_TOP_KNEE) begin
                        flr = FLOOR_TOP;
                    end else begin
                        flr = (cap > CAP_IDLE_KNEE) ? cap - WINDOW_OFFSET : FLOOR_RESET;
                        if (flr > FLOOR_TOP) flr = FLOOR_TOP;
                    end
                    win_floor = 15'(flr);
                    win_span  = SPAN_DEFAULT;
                end
                prev_boost = t.boost_level;
                // linear gain across the window
                if (cap <= win_floor) begin
                    gain = GAIN_FLOOR;
                end else if (win_span == 0) begin
                    gain = Q_ONE;
                end else begin
                    gain = ((cap - win_floor) * 32768) / win_span;
                    if (gain < GAIN_FLOOR) gain = GAIN_FLOOR;
                    if (gain > Q_ONE) gain = Q_ONE;
                end
            end else if (!t.referee_offline) begin
                // slow over-limit gain, stepped once per RATIO fallback ticks
                div = fb_count % RATIO;
                if (div == 0 && t.buffer_energy <= BUF_STEP)
                    ovf_gain = (ovf_gain > OVF_MIN + OVF_STEP) ? ovf_gain - OVF_STEP : OVF_MIN;
                fb_count = 7'(div + 1);
                if (energy <= BUF_BASE) begin
                    gain = FB_LOW;
                end else begin
                    gain = ((energy - BUF_BASE) * ovf_gain) / BUF_SCALE;
                    if (gain < FB_LOW) gain = FB_LOW;
                    if (gain > FB_HIGH) gain = FB_HIGH;
                end
            end else begin
                gain = GAIN_LOCAL;
            end

            // under-voltage scaling, skipped without module or current reading
            if (!t.module_offline && t.present_current != 0) begin
                if (t.allowed_current >= t.present_current)
                    factor = Q_ONE;
                else
                    factor = (t.allowed_current * 32768) / t.present_current;
                uv_last = 16'(factor);
                gain    = (gain * factor) >> 15;
            end

            res.limit_gain     = 16'(gain);
            res.undervolt_gain = uv_last;
            expected_q.push_back(res);
        endfunction

        // Compare an accepted result with the oldest expectation
        task check_result(gain_result_t got);
            gain_result_t want;
            if (expected_q.size() == 0) begin
                report("result with nothing expected", got, 0);
            end else begin
                want = expected_q.pop_front();
                if (got.limit_gain !== want.limit_gain)
                    report("limit_gain", got.limit_gain, want.limit_gain);
                if (got.undervolt_gain !== want.undervolt_gain)
                    report("undervolt_gain", got.undervolt_gain, want.undervolt_gain);
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // cap_level[14:0], buffer_energy[22:15], boost_level[24:23], module_offline[25],
    // referee_offline[26], cap_healthy[27], allowed_current[43:28],
    // present_current[59:44], zero[63:60]
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // limit_gain[15:0], undervolt_gain[31:16]
    logic [31:0] m_tdata;

    gain_scoreboard board = new();
    logic [1:0]     held_boost = BOOST_NONE;

    power_limit_gain #(
        .DIVIDE_RATIO(RATIO)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic tick_t make_tick(int unsigned cap, int unsigned energy,
                                        logic [1:0] boost, logic mod_off, logic referee_off,
                                        logic healthy, int unsigned allowed,
                                        int unsigned present);
        tick_t t;
        t                 = '0;
        t.cap_level       = 15'(cap);
        t.buffer_energy   = 8'(energy);
        t.boost_level     = boost;
        t.module_offline  = mod_off;
        t.referee_offline = referee_off;
        t.cap_healthy     = healthy;
        t.allowed_current = 16'(allowed);
        t.present_current = 16'(present);
        return t;
    endfunction

    // Random tick, weighted towards fallback mode so the over-limit gain moves
    function automatic tick_t random_tick();
        tick_t       t;
        tick_mode_t  mode;
        int unsigned pick;
        t    = '0;
        pick = $urandom_range(0, 99);
        mode = (pick < 30) ? MODE_REGULAR : (pick < 88) ? MODE_FALLBACK : MODE_LOCAL;
        if ($urandom_range(0, 3) == 0) held_boost = 2'($urandom_range(0, 3));
        t.boost_level = held_boost;
        t.cap_level   = ($urandom_range(0, 4) == 0) ? 15'($urandom_range(0, 32767))
                                                    : 15'($urandom_range(8000, 30000));
        case (mode)
            MODE_REGULAR: begin
                t.module_offline  = 1'b0;
                t.referee_offline = 1'($urandom_range(0, 1));
                t.cap_healthy     = ($urandom_range(0, 3) != 0);
                t.buffer_energy   = t.cap_healthy ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(40, 255));
            end
            MODE_FALLBACK: begin
                t.referee_offline = 1'b0;
                t.module_offline  = ($urandom_range(0, 3) == 0);
                t.cap_healthy     = t.module_offline ? 1'($urandom_range(0, 1)) : 1'b0;
                pick = $urandom_range(0, 99);
                t.buffer_energy   = (pick < 70) ? 8'($urandom_range(0, 20))
                                  : (pick < 90) ? 8'($urandom_range(21, 39))
                                                : 8'($urandom_range(0, 255));
            end
            default: begin
                t.referee_offline = 1'b1;
                t.module_offline  = 1'($urandom_range(0, 1));
                t.cap_healthy     = t.module_offline ? 1'($urandom_range(0, 1)) : 1'b0;
                t.buffer_energy   = t.module_offline ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 39));
            end
        endcase
        t.allowed_current = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        t.present_current = (pick < 15) ? 16'd0
                          : (pick < 55) ? 16'($urandom_range(0, t.allowed_current))
                                        : 16'($urandom_range(0, 65535));
        return t;
    endfunction

    // Offer one tick from a falling edge; returns at the falling edge after the transfer
    task automatic send_tick(input tick_t t);
        s_tdata  <= t;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_input(t);
        @(negedge aclk);
    endtask

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    // Receiver stalls: stretches of always-ready, a fixed pattern, or coin flips
    initial begin
        int unsigned  stretch;
        int unsigned  phase;
        stall_style_t style;
        m_tready = 1'b0;
        stretch  = 0;
        phase    = 0;
        style    = RX_ALWAYS;
        forever begin
            @(negedge aclk);
            if (stretch == 0) begin
                stretch = $urandom_range(8, 80);
                style   = stall_style_t'($urandom_range(0, 2));
            end
            stretch--;
            phase++;
            case (style)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_PATTERN: m_tready <= READY_PATTERN[phase % 16];
                default:    m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        tick_t       directed[$];
        int unsigned sent;
        int unsigned total;
        int unsigned burst;
        int unsigned gap;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        aresetn  = 1'b0;

        // Extremes, every mode and boost transition, protection skipped and applied
        directed.push_back(make_tick(0,     0,   BOOST_NONE, 0, 0, 1, 0,     0));
        directed.push_back(make_tick(32767, 255, BOOST_NONE, 0, 0, 1, 65535, 65535));
        directed.push_back(make_tick(30000, 60,  2'd1,       0, 0, 1, 1,     65535));
        directed.push_back(make_tick(20000, 45,  2'd2,       0, 0, 0, 65535, 1));
        directed.push_back(make_tick(13500, 0,   BOOST_JUMP, 0, 0, 1, 300,   1000));
        directed.push_back(make_tick(14000, 0,   2'd1,       0, 0, 1, 1000,  300));
        directed.push_back(make_tick(16000, 0,   BOOST_NONE, 0, 0, 1, 0,     65535));
        directed.push_back(make_tick(15000, 40,  BOOST_NONE, 0, 0, 0, 500,   0));
        directed.push_back(make_tick(17000, 41,  2'd1,       0, 0, 1, 123,   456));
        directed.push_back(make_tick(27899, 0,   BOOST_NONE, 0, 1, 1, 40000, 50000));
        directed.push_back(make_tick(27900, 0,   BOOST_NONE, 0, 0, 1, 2,     3));
        directed.push_back(make_tick(30001, 0,   2'd2,       0, 0, 1, 9,     8));
        directed.push_back(make_tick(10000, 0,   BOOST_NONE, 0, 0, 1, 0,     0));
        directed.push_back(make_tick(9000,  0,   BOOST_NONE, 0, 0, 1, 0,     0));
        directed.push_back(make_tick(20000, 20,  BOOST_NONE, 0, 0, 0, 0,     0));
        directed.push_back(make_tick(5000,  39,  BOOST_NONE, 0, 0, 0, 1000,  2000));
        directed.push_back(make_tick(5000,  10,  2'd1,       0, 0, 0, 7000,  7000));
        directed.push_back(make_tick(29000, 255, BOOST_JUMP, 1, 0, 1, 100,   200));
        directed.push_back(make_tick(0,     0,   BOOST_NONE, 1, 0, 0, 65535, 65535));
        directed.push_back(make_tick(25000, 35,  2'd2,       0, 0, 0, 65534, 65535));
        directed.push_back(make_tick(12345, 30,  BOOST_NONE, 1, 1, 1, 1,     2));
        directed.push_back(make_tick(22222, 39,  BOOST_NONE, 0, 1, 0, 100,   300));
        directed.push_back(make_tick(32767, 255, BOOST_JUMP, 1, 1, 1, 65535, 65534));

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Bursts of transfers with random gaps; valid stays high across a zero gap
        sent  = 0;
        total = directed.size() + RANDOM_TICKS;
        while (sent < total) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < total) begin
                send_tick((sent < directed.size()) ? directed[sent] : random_tick());
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for any late spurious result
        while (board.pending() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
